// ===== rtl/core/rpvg_pkg.sv =====
// ----------------------------------------------------------------------------
// rpvg_pkg
// Shared constants and the arctangent table for the polygon vertex generator.
// ----------------------------------------------------------------------------
package rpvg_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int STEP_BITS = 5;
  localparam logic [31:0] CORDIC_ONE = 32'd652032875;
  localparam logic [31:0] RADIUS_MIN = 32'd6;
  localparam logic [6:0] SIDES_RESET = 7'd6;

  function automatic logic [31:0] turn_atan(input logic [STEP_BITS-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/rpvg_vec_cell.sv =====
// ----------------------------------------------------------------------------
// rpvg_vec_cell
// One vectoring step of the heading angle chain, registered.
// ----------------------------------------------------------------------------
module rpvg_vec_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic signed [34:0] x_in,
  input  logic signed [34:0] z_in,
  input  logic [31:0]        acc_in,
  output logic signed [34:0] x_out,
  output logic signed [34:0] z_out,
  output logic [31:0]        acc_out
);
  import rpvg_pkg::*;

  logic signed [34:0] x_r, z_r;
  logic [31:0] acc_r;

  always_ff @(posedge clk) begin
    if (z_in > 0) begin
      x_r <= x_in + (z_in >>> STEP);
      z_r <= z_in - (x_in >>> STEP);
      acc_r <= acc_in + turn_atan(STEP_BITS'(STEP));
    end else begin
      x_r <= x_in - (z_in >>> STEP);
      z_r <= z_in + (x_in >>> STEP);
      acc_r <= acc_in - turn_atan(STEP_BITS'(STEP));
    end
  end

  assign x_out = x_r;
  assign z_out = z_r;
  assign acc_out = acc_r;
endmodule

// ===== rtl/core/rpvg_rot_cell.sv =====
// ----------------------------------------------------------------------------
// rpvg_rot_cell
// One rotation step of the cosine and sine chain, registered, with tags.
// ----------------------------------------------------------------------------
module rpvg_rot_cell #(
  parameter int STEP = 0,
  parameter int TAG_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  logic [TAG_BITS-1:0] tag_in,
  input  logic signed [33:0]  x_in,
  input  logic signed [33:0]  y_in,
  input  logic signed [33:0]  r_in,
  output logic                vld_out,
  output logic [TAG_BITS-1:0] tag_out,
  output logic signed [33:0]  x_out,
  output logic signed [33:0]  y_out,
  output logic signed [33:0]  r_out
);
  import rpvg_pkg::*;

  logic vld_r;
  logic [TAG_BITS-1:0] tag_r;
  logic signed [33:0] x_r, y_r, r_r, at;

  assign at = $signed({2'b00, turn_atan(STEP_BITS'(STEP))});

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_in;
    tag_r <= tag_in;
    if (r_in >= 0) begin
      x_r <= x_in - (y_in >>> STEP);
      y_r <= y_in + (x_in >>> STEP);
      r_r <= r_in - at;
    end else begin
      x_r <= x_in + (y_in >>> STEP);
      y_r <= y_in - (x_in >>> STEP);
      r_r <= r_in + at;
    end
  end

  assign vld_out = vld_r;
  assign tag_out = tag_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign r_out = r_r;
endmodule

// ===== rtl/core/regular_polygon_vertex_generator_unit.sv =====
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_unit
// Emits the vertices of a regular polygon around a center point.
// ----------------------------------------------------------------------------
// Flow: after start is accepted, the heading passes the vectoring chain, then
// a restoring division and one issue step produce the first vertex angle, which
// then passes 28 rotation cells and three output stages. Each later vertex takes
// one new division plus one issue step. busy is high while an item is in flight;
// an item that emits nothing leaves busy low.
// Results cannot be stalled. Synchronous reset sets side_count 6.
module regular_polygon_vertex_generator_unit #(
  parameter int MAX_SIDES = 64,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_side_count,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_heading_x,
  input  logic signed [31:0] in_heading_z,
  input  logic [31:0]        in_circumradius,
  output logic               out_valid,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic signed [31:0] out_vertex_z,
  output logic [5:0]         out_vertex_number,
  output logic               out_last_vertex
);
  import rpvg_pkg::*;

  localparam int NB = 7;
  localparam int TAG_BITS = 7;
  localparam int DIVW = ANGLE_BITS + NB;
  localparam logic [1:0] S_IDLE = 2'd0, S_VEC = 2'd1, S_EMIT = 2'd2, S_DRAIN = 2'd3;

  logic [6:0] sides_r;
  logic [1:0] state_r;
  logic [5:0] cnt_r;
  logic [6:0] n_r, idx_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [31:0] rad_r;
  logic zero_r;
  logic [ANGLE_BITS-1:0] start_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sides_r <= SIDES_RESET;
    else if (cfg_we) sides_r <= cfg_side_count;
  end

  // Vectoring chain for the start angle.
  logic signed [34:0] vx [0:CORDIC_STEPS];
  logic signed [34:0] vz [0:CORDIC_STEPS];
  logic [31:0] va [0:CORDIC_STEPS];
  logic signed [34:0] hx_in, hz_in;
  logic signed [34:0] vx0_r, vz0_r;
  logic [31:0] va0_r;

  assign hx_in = 35'(in_heading_x);
  assign hz_in = 35'(in_heading_z);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      if (in_heading_x < 0) begin
        vx0_r <= -hx_in; vz0_r <= -hz_in; va0_r <= 32'h8000_0000;
      end else begin
        vx0_r <= hx_in; vz0_r <= hz_in; va0_r <= 32'd0;
      end
    end
  end
  assign vx[0] = vx0_r;
  assign vz[0] = vz0_r;
  assign va[0] = va0_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    rpvg_vec_cell #(.STEP(g)) u_cell (
      .clk(clk), .x_in(vx[g]), .z_in(vz[g]), .acc_in(va[g]),
      .x_out(vx[g+1]), .z_out(vz[g+1]), .acc_out(va[g+1])
    );
  end

  logic [31:0] acc_round;
  assign acc_round = va[CORDIC_STEPS] + (32'd1 << (31 - ANGLE_BITS));

  // Vertex offset divider: quotient of (i*2^A + n/2) / n.
  logic [DIVW-1:0] dnum_r, dquo_r;
  logic [NB:0] drem_r;
  logic [4:0] dbit_r;
  logic div_busy_r;
  logic [NB:0] dtrial;
  logic [ANGLE_BITS-1:0] off_ang;
  assign dtrial = {drem_r[NB-1:0], dnum_r[DIVW-1]} - {1'b0, n_r};

  // Rotation chain input.
  logic rv [0:CORDIC_STEPS];
  logic [TAG_BITS-1:0] rt [0:CORDIC_STEPS];
  logic signed [33:0] rx [0:CORDIC_STEPS];
  logic signed [33:0] ry [0:CORDIC_STEPS];
  logic signed [33:0] rr [0:CORDIC_STEPS];
  logic rv0_r;
  logic [TAG_BITS-1:0] rt0_r;
  logic signed [33:0] rr0_r;
  logic [31:0] tang;

  // Flip flag travels in the tag's top bit with the 6-bit index below.
  assign off_ang = start_ang_r + dquo_r[ANGLE_BITS-1:0];
  assign tang = {off_ang, {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      div_busy_r <= 1'b0;
      rv0_r <= 1'b0;
    end else begin
      rv0_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cx_r <= in_center_x; cy_r <= in_center_y; cz_r <= in_center_z;
            rad_r <= in_circumradius;
            zero_r <= (in_heading_x == 0) && (in_heading_z == 0);
            n_r <= (sides_r > 7'(MAX_SIDES)) ? 7'(MAX_SIDES) : sides_r;
            if (sides_r >= 7'd3 && in_circumradius > RADIUS_MIN) begin
              state_r <= S_VEC;
              cnt_r <= 6'd0;
            end
          end
        end
        S_VEC: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CORDIC_STEPS)) begin
            start_ang_r <= zero_r ? '0 : acc_round[31 -: ANGLE_BITS];
            state_r <= S_EMIT;
            idx_r <= 7'd0;
            dnum_r <= DIVW'(n_r >> 1);
            drem_r <= '0;
            dquo_r <= '0;
            dbit_r <= 5'd0;
            div_busy_r <= 1'b1;
          end
        end
        S_EMIT: begin
          if (div_busy_r) begin
            dnum_r <= dnum_r << 1;
            if (!dtrial[NB]) begin
              drem_r <= dtrial;
              dquo_r <= {dquo_r[DIVW-2:0], 1'b1};
            end else begin
              drem_r <= {drem_r[NB-1:0], dnum_r[DIVW-1]};
              dquo_r <= {dquo_r[DIVW-2:0], 1'b0};
            end
            dbit_r <= dbit_r + 5'd1;
            if (dbit_r == 5'(DIVW - 1)) div_busy_r <= 1'b0;
          end else begin
            rv0_r <= 1'b1;
            rt0_r <= {tang >= 32'h4000_0000 && tang < 32'hC000_0000, idx_r[5:0]};
            if (tang >= 32'h4000_0000 && tang < 32'hC000_0000)
              rr0_r <= 34'($signed(tang - 32'h8000_0000));
            else
              rr0_r <= 34'($signed(tang));
            idx_r <= idx_r + 7'd1;
            if (idx_r + 7'd1 == n_r) begin
              state_r <= S_DRAIN;
              cnt_r <= 6'd0;
            end else begin
              dnum_r <= (DIVW'(idx_r + 7'd1) << ANGLE_BITS) + DIVW'(n_r >> 1);
              drem_r <= '0;
              dquo_r <= '0;
              dbit_r <= 5'd0;
              div_busy_r <= 1'b1;
            end
          end
        end
        S_DRAIN: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CORDIC_STEPS + 4)) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  assign rv[0] = rv0_r;
  assign rt[0] = rt0_r;
  assign rx[0] = 34'(CORDIC_ONE);
  assign ry[0] = '0;
  assign rr[0] = rr0_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    rpvg_rot_cell #(.STEP(g), .TAG_BITS(TAG_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .vld_in(rv[g]), .tag_in(rt[g]),
      .x_in(rx[g]), .y_in(ry[g]), .r_in(rr[g]),
      .vld_out(rv[g+1]), .tag_out(rt[g+1]),
      .x_out(rx[g+1]), .y_out(ry[g+1]), .r_out(rr[g+1])
    );
  end

  // Fold back, scale by the radius, round and saturate.
  logic v1_r, v2_r, v3_r;
  logic [5:0] i1_r, i2_r, i3_r;
  logic signed [33:0] c1_r, s1_r;
  logic signed [67:0] pc_r, ps_r;
  logic signed [35:0] sx_r, sz_r;
  logic signed [35:0] qc, qs;

  assign qc = 36'((pc_r + 68'sd536870912) >>> 30);
  assign qs = 36'((ps_r + 68'sd536870912) >>> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= rv[CORDIC_STEPS]; v2_r <= v1_r; v3_r <= v2_r;
    end
    i1_r <= rt[CORDIC_STEPS][5:0];
    c1_r <= rt[CORDIC_STEPS][6] ? -rx[CORDIC_STEPS] : rx[CORDIC_STEPS];
    s1_r <= rt[CORDIC_STEPS][6] ? -ry[CORDIC_STEPS] : ry[CORDIC_STEPS];
    i2_r <= i1_r;
    pc_r <= 68'(c1_r) * $signed({36'd0, rad_r});
    ps_r <= 68'(s1_r) * $signed({36'd0, rad_r});
    i3_r <= i2_r;
    sx_r <= qc + 36'(cx_r);
    sz_r <= qs + 36'(cz_r);
  end

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -36'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign out_valid = v3_r;
  assign out_vertex_x = sat32(sx_r);
  assign out_vertex_z = sat32(sz_r);
  assign out_vertex_y = cy_r;
  assign out_vertex_number = i3_r;
  assign out_last_vertex = (7'(i3_r) + 7'd1 == n_r);
endmodule
